>>> design/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg: shared types and constants for the sorted multiset
// Field widths, command and status codes, controller states and cell control.
// ----------------------------------------------------------------------------
package rss_pkg;

  localparam int unsigned OpcodeBits = 1;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned RankBits   = 11;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned CountBits  = 11;

  localparam int unsigned DefCapacity  = 1024;
  localparam int unsigned DefValueBits = 32;

  // cells per segment of the result gather chain
  localparam int unsigned SegCells = 32;

  typedef enum logic [OpcodeBits-1:0] {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_e;

  typedef enum logic [StatusBits-1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_BAD_RANK = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_GATHER = 1'b1
  } state_e;

  typedef struct packed {
    logic apply;
    logic remove;
  } cell_ctl_t;

endpackage

>>> design/rss_if.sv
// ----------------------------------------------------------------------------
// rss_if: request and response channels of the sorted multiset
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface rss_req_if;
  import rss_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OpcodeBits-1:0] opcode;
  logic [ValueBits-1:0]  value;
  logic [RankBits-1:0]   rank;

  modport source (output valid, output opcode, output value, output rank, input ready);
  modport sink   (input valid, input opcode, input value, input rank, output ready);
endinterface

interface rss_rsp_if;
  import rss_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ValueBits-1:0]  removed_value;
  logic [StatusBits-1:0] status;
  logic [CountBits-1:0]  live_count;

  modport source (output valid, output removed_value, output status, output live_count,
                  input ready);
  modport sink   (input valid, input removed_value, input status, input live_count,
                  output ready);
endinterface

>>> design/rss_cell.sv
// ----------------------------------------------------------------------------
// rss_cell: one slot of the sorted row
// Holds one value; on insert it keeps, takes the new value or takes its left
// neighbour's; on remove at or after the hole it takes its right neighbour's.
// ----------------------------------------------------------------------------
module rss_cell
  import rss_pkg::*;
#(
  parameter int unsigned VB    = DefValueBits,
  parameter int unsigned CNT_W = 11,
  parameter int unsigned IDX_W = 10,
  parameter int unsigned IDX   = 0
) (
  input  logic             clk_i,
  input  cell_ctl_t        ctl_i,
  input  logic [VB-1:0]    x_i,
  input  logic [CNT_W-1:0] cnt_i,
  input  logic [IDX_W-1:0] idx_i,
  input  logic [VB-1:0]    left_val_i,
  input  logic             left_gt_i,
  input  logic [VB-1:0]    right_val_i,
  output logic [VB-1:0]    val_o,
  output logic             gt_o,
  output logic [VB-1:0]    pick_o
);

  logic [VB-1:0] val_q, val_d;
  logic          gt;

  // empty slots count as greater, so the flags along the row stay monotone
  assign gt = (CNT_W'(IDX) >= cnt_i) || (val_q > x_i);

  always_comb begin
    val_d = val_q;
    if (ctl_i.apply) begin
      if (ctl_i.remove) begin
        if (IDX_W'(IDX) >= idx_i) begin
          val_d = right_val_i;
        end
      end else if (gt) begin
        val_d = left_gt_i ? left_val_i : x_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o  = val_q;
  assign gt_o   = gt;
  assign pick_o = (IDX_W'(IDX) == idx_i) ? val_q : '0;

endmodule

>>> design/rss_gather.sv
// ----------------------------------------------------------------------------
// rss_gather: collects the removed value from the row
// Each segment ORs its cells' picks into a register; the segment registers
// then merge towards segment zero, one neighbour step per cycle while merge_i is high.
// ----------------------------------------------------------------------------
module rss_gather
  import rss_pkg::*;
#(
  parameter int unsigned VB  = DefValueBits,
  parameter int unsigned CAP = DefCapacity
) (
  input  logic          clk_i,
  input  logic          load_i,
  input  logic          merge_i,
  input  logic [VB-1:0] pick_i [CAP],
  output logic [VB-1:0] taken_o
);

  localparam int unsigned Seg  = (CAP < SegCells) ? CAP : SegCells;
  localparam int unsigned NSeg = (CAP + Seg - 1) / Seg;

  logic [VB-1:0] pad [NSeg*Seg];
  logic [VB-1:0] seg_q [NSeg];
  logic [VB-1:0] seg_d [NSeg];

  for (genvar gi = 0; gi < NSeg * Seg; gi++) begin : g_pad
    if (gi < CAP) begin : g_real
      assign pad[gi] = pick_i[gi];
    end else begin : g_zero
      assign pad[gi] = '0;
    end
  end

  always_comb begin
    logic [VB-1:0] acc;
    acc = '0;
    for (int j = 0; j < NSeg; j++) begin
      seg_d[j] = seg_q[j];
      if (load_i) begin
        acc = '0;
        for (int c = 0; c < Seg; c++) begin
          acc = acc | pad[j*Seg+c];
        end
        seg_d[j] = acc;
      end else if (merge_i && (j + 1 < NSeg)) begin
        seg_d[j] = seg_q[j] | seg_q[(j+1)%NSeg];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
  end

  assign taken_o = seg_q[0];

endmodule

>>> design/rank_select_sorted_multiset.sv
// ----------------------------------------------------------------------------
// rank_select_sorted_multiset: order-statistic multiset on a row of cells
// Inserts keep the row sorted (new value after equal ones); removes take the
// k-th smallest by 1-based rank and close the gap.
//
//   channel  dir  payload                              transfer
//   req_i    in   opcode, value, rank                  valid & ready
//   rsp_o    out  removed_value, status, live_count    valid & ready
//
// Insert, full-store and bad-rank requests: the response is registered at the
// accepting edge. A successful remove answers once the segment chain has
// brought the removed value to segment zero. Every cell updates in the
// accepting cycle. Reset empties the store at once. A new request is taken
// only when idle and the response register is empty or being drained in the
// same cycle.
// ----------------------------------------------------------------------------
module rank_select_sorted_multiset
  import rss_pkg::*;
#(
  parameter int unsigned CAPACITY   = DefCapacity,
  parameter int unsigned VALUE_BITS = DefValueBits
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rss_req_if.sink   req_i,
  rss_rsp_if.source rsp_o
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW  = $clog2(CAPACITY);
  localparam int unsigned CmpW  = (CntW > RankBits) ? CntW : RankBits;
  localparam int unsigned Seg   = (CAPACITY < SegCells) ? CAPACITY : SegCells;
  localparam int unsigned NSeg  = (CAPACITY + Seg - 1) / Seg;
  localparam int unsigned SegCW = (NSeg > 1) ? $clog2(NSeg) : 1;

  state_e                state_q, state_d;
  logic [SegCW-1:0]      seg_cnt_q, seg_cnt_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic [CntW-1:0]       out_count_q, out_count_d;
  logic [ValueBits-1:0]  out_value_q, out_value_d;

  logic [VALUE_BITS-1:0] x;
  logic [IdxW-1:0]       idx;
  logic                  accept, is_remove, full, bad_rank, rem_ok, ins_ok, gather_done;
  logic                  load, merge;
  cell_ctl_t             ctl;
  logic [VALUE_BITS-1:0] taken;

  logic [VALUE_BITS-1:0] val  [CAPACITY];
  logic [VALUE_BITS-1:0] pick [CAPACITY];
  logic                  gt   [CAPACITY];

  assign x         = VALUE_BITS'(req_i.value);
  assign idx       = IdxW'(req_i.rank - RankBits'(1));
  assign is_remove = (req_i.opcode == OP_REMOVE);
  assign full      = (cnt_q == CntW'(CAPACITY));
  assign bad_rank  = (req_i.rank == '0) || (CmpW'(req_i.rank) > CmpW'(cnt_q));
  assign accept    = req_i.valid && req_i.ready;
  assign ins_ok    = accept && !is_remove && !full;
  assign rem_ok    = accept && is_remove && !bad_rank;
  assign gather_done = (state_q == S_GATHER) && (seg_cnt_q == '0);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:   if (rem_ok) state_d = S_GATHER;
      S_GATHER: if (seg_cnt_q == '0) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    req_i.ready = 1'b0;
    load        = 1'b0;
    merge       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_i.ready = !out_valid_q || rsp_o.ready;
        load        = rem_ok;
      end
      S_GATHER: begin
        merge = 1'b1;
      end
      default: ;
    endcase
  end

  assign ctl.apply  = ins_ok || rem_ok;
  assign ctl.remove = is_remove;

  // datapath registers
  always_comb begin
    seg_cnt_d    = seg_cnt_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    out_value_d  = out_value_q;
    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_GATHER) begin
      seg_cnt_d = seg_cnt_q - SegCW'(1);
    end
    if (accept) begin
      out_value_d = '0;
      if (!is_remove) begin
        out_valid_d = 1'b1;
        if (full) begin
          out_status_d = ST_FULL;
          out_count_d  = cnt_q;
        end else begin
          out_status_d = ST_INSERTED;
          cnt_d        = cnt_q + CntW'(1);
          out_count_d  = cnt_q + CntW'(1);
        end
      end else if (bad_rank) begin
        out_valid_d  = 1'b1;
        out_status_d = ST_BAD_RANK;
        out_count_d  = cnt_q;
      end else begin
        out_status_d = ST_REMOVED;
        cnt_d        = cnt_q - CntW'(1);
        out_count_d  = cnt_q - CntW'(1);
        seg_cnt_d    = SegCW'(NSeg - 1);
      end
    end
    if (gather_done) begin
      out_valid_d = 1'b1;
      out_value_d = ValueBits'(taken);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      seg_cnt_q   <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      seg_cnt_q   <= seg_cnt_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
    out_value_q  <= out_value_d;
  end

  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [VALUE_BITS-1:0] left_val, right_val;
    logic                  left_gt;

    if (gi == 0) begin : g_first
      assign left_val = x;
      assign left_gt  = 1'b0;
    end else begin : g_mid
      assign left_val = val[gi-1];
      assign left_gt  = gt[gi-1];
    end
    if (gi == CAPACITY - 1) begin : g_last
      assign right_val = val[gi];
    end else begin : g_inner
      assign right_val = val[gi+1];
    end

    rss_cell #(
      .VB    (VALUE_BITS),
      .CNT_W (CntW),
      .IDX_W (IdxW),
      .IDX   (gi)
    ) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .x_i         (x),
      .cnt_i       (cnt_q),
      .idx_i       (idx),
      .left_val_i  (left_val),
      .left_gt_i   (left_gt),
      .right_val_i (right_val),
      .val_o       (val[gi]),
      .gt_o        (gt[gi]),
      .pick_o      (pick[gi])
    );
  end

  rss_gather #(
    .VB  (VALUE_BITS),
    .CAP (CAPACITY)
  ) u_gather (
    .clk_i   (clk_i),
    .load_i  (load),
    .merge_i (merge),
    .pick_i  (pick),
    .taken_o (taken)
  );

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.removed_value = out_value_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.live_count    = CountBits'(out_count_q);

endmodule
